// File: design/sps_pkg.sv
package sps_pkg;

  localparam int unsigned PhasesDefault = 24;
  localparam int unsigned HomePhase     = 12;
  localparam int unsigned PhaseW        = 5;
  localparam int unsigned PosW          = 16;
  localparam int unsigned AngleW        = 12;
  localparam int unsigned BudgetW       = 8;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned InDataW       = 32;
  localparam int unsigned InUserW       = 8;
  localparam int unsigned OutDataW      = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_TARGET  = 2'd0,
    CFG_WINDOW_LOW  = 2'd1,
    CFG_WINDOW_HIGH = 2'd2,
    CFG_HOME_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HOME_NONE   = 2'd0,
    HOME_FOUND  = 2'd1,
    HOME_BUDGET = 2'd2,
    HOME_ABORT  = 2'd3
  } home_result_e;

  typedef struct packed {
    logic [PosW-1:0]    max_target_step;
    logic [AngleW-1:0]  zero_window_low;
    logic [AngleW-1:0]  zero_window_high;
    logic [BudgetW-1:0] home_step_limit;
  } cfg_t;

  typedef struct packed {
    logic              home_request;
    logic              new_target;
    logic [PosW-1:0]   target_step;
    logic [AngleW-1:0] angle_sample;
    logic              abort_button;
  } tick_t;

  typedef struct packed {
    logic [7:0]      phase_pattern;
    logic            step_taken;
    logic            step_up;
    logic [PosW-1:0] position;
    logic            moving;
    logic            over_limit;
    logic            homing;
    home_result_e    home_result;
  } result_t;

  // Coil pattern table; entries past the defined patterns read as zero.
  function automatic logic [7:0] coil_pattern(input logic [PhaseW-1:0] idx);
    logic [7:0] pat;
    unique case (idx)
      5'd0:  pat = 8'hC0;
      5'd1:  pat = 8'hC1;
      5'd2:  pat = 8'hC2;
      5'd3:  pat = 8'hC3;
      5'd4:  pat = 8'h83;
      5'd5:  pat = 8'h43;
      5'd6:  pat = 8'h03;
      5'd7:  pat = 8'h07;
      5'd8:  pat = 8'h0B;
      5'd9:  pat = 8'h0F;
      5'd10: pat = 8'h0E;
      5'd11: pat = 8'h0D;
      5'd12: pat = 8'h0C;
      5'd13: pat = 8'h1C;
      5'd14: pat = 8'h2C;
      5'd15: pat = 8'h3C;
      5'd16: pat = 8'h38;
      5'd17: pat = 8'h34;
      5'd18: pat = 8'h30;
      5'd19: pat = 8'h70;
      5'd20: pat = 8'hB0;
      5'd21: pat = 8'hF0;
      5'd22: pat = 8'hE0;
      5'd23: pat = 8'hD0;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// File: design/stepper_phase_sequencer_with_homing_unit.sv
// Stepper phase sequencer with zero search.
// A result is registered and appears in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle; the combinational next-state logic and the
// output register set this, and while a result waits unaccepted no new tick is taken.
// Reset (rst_ni low, asynchronous): motion state cleared, config registers at defaults.
module stepper_phase_sequencer_with_homing_unit #(
  parameter int unsigned PHASES = sps_pkg::PhasesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] target_step, [27:16] angle_sample, [28] abort_button, rest zero
  input  logic [sps_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] home_request, [1] new_target, rest zero
  input  logic [sps_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] phase_pattern, [8] step_taken, [9] step_up, [25:10] position,
  // [26] moving, [27] over_limit, [28] homing, [30:29] home_result, [31] zero
  output logic [sps_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import sps_pkg::*;

  cfg_t    cfg_q;
  tick_t   tick;
  result_t result, result_q;
  logic    out_valid_q;
  logic    in_accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_target_step  <= 16'd65535;
      cfg_q.zero_window_low  <= 12'd49;
      cfg_q.zero_window_high <= 12'd54;
      cfg_q.home_step_limit  <= 8'd80;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_TARGET:  cfg_q.max_target_step  <= cfg_data_i;
        CFG_WINDOW_LOW:  cfg_q.zero_window_low  <= cfg_data_i[AngleW-1:0];
        CFG_WINDOW_HIGH: cfg_q.zero_window_high <= cfg_data_i[AngleW-1:0];
        CFG_HOME_LIMIT:  cfg_q.home_step_limit  <= cfg_data_i[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick.home_request = s_axis_tuser_i[0];
    tick.new_target   = s_axis_tuser_i[1];
    tick.target_step  = s_axis_tdata_i[15:0];
    tick.angle_sample = s_axis_tdata_i[27:16];
    tick.abort_button = s_axis_tdata_i[28];
  end

  sps_core #(
    .PHASES(PHASES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_valid_i(in_accept),
    .tick_i      (tick),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, result_q.home_result, result_q.homing, result_q.over_limit,
                            result_q.moving, result_q.position, result_q.step_up,
                            result_q.step_taken, result_q.phase_pattern};

  // A finished search reports its outcome only once homing has dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.homing && result_q.home_result != HOME_NONE))
    else $error("home result reported while still homing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.step_up |-> result_q.step_taken)
    else $error("upward step flagged without a step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("tick accepted while result stalled");

endmodule

// File: design/sps_core.sv
module sps_core #(
  parameter int unsigned PHASES = sps_pkg::PhasesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_valid_i,
  input  sps_pkg::tick_t   tick_i,
  input  sps_pkg::cfg_t    cfg_i,
  output sps_pkg::result_t result_o
);
  import sps_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_MOVING,
    MODE_HOMING
  } mode_e;

  localparam logic [PhaseW-1:0] LastPhase  = PhaseW'(PHASES - 1);
  localparam logic [PhaseW-1:0] HomeIdx    = PhaseW'(HomePhase % PHASES);
  localparam logic [PhaseW-1:0] HomeUpIdx  = (HomeIdx >= LastPhase) ? '0 : HomeIdx + 1'b1;
  localparam logic [PhaseW:0]   PhaseCount = (PhaseW + 1)'(PHASES);

  mode_e              mode_q, mode_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    tgt_q, tgt_d;
  logic [BudgetW-1:0] left_q, left_d;
  logic               ovf_q, ovf_d;

  logic [PhaseW-1:0]  phase_up, phase_dn;
  logic [PosW-1:0]    diff;
  logic               in_window;
  logic               stepped, went_up;
  home_result_e       res;

  assign phase_up  = (phase_q >= LastPhase) ? '0 : phase_q + 1'b1;
  assign phase_dn  = (phase_q == '0 || {1'b0, phase_q} >= PhaseCount) ? LastPhase
                                                                    : phase_q - 1'b1;
  assign in_window = (tick_i.angle_sample >= cfg_i.zero_window_low) &&
                     (tick_i.angle_sample <= cfg_i.zero_window_high);

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    left_d  = left_q;
    ovf_d   = ovf_q;
    stepped = 1'b0;
    went_up = 1'b0;
    res     = HOME_NONE;
    diff    = '0;
    if (mode_q == MODE_HOMING) begin
      if (in_window) begin
        pos_d  = '0;
        tgt_d  = '0;
        mode_d = MODE_IDLE;
        res    = HOME_FOUND;
      end else if (left_q == '0) begin
        mode_d = MODE_IDLE;
        res    = HOME_BUDGET;
        tgt_d  = pos_q;
      end else begin
        phase_d = phase_up;
        pos_d   = pos_q + 1'b1;
        tgt_d   = pos_q + 1'b1;
        left_d  = left_q - 1'b1;
        stepped = 1'b1;
        went_up = 1'b1;
        if (tick_i.abort_button) begin
          mode_d = MODE_IDLE;
          res    = HOME_ABORT;
        end
      end
    end else if (tick_i.home_request) begin
      phase_d = HomeUpIdx;
      pos_d   = pos_q + 1'b1;
      tgt_d   = pos_q + 1'b1;
      left_d  = cfg_i.home_step_limit;
      stepped = 1'b1;
      went_up = 1'b1;
      mode_d  = MODE_HOMING;
    end else begin
      if (tick_i.new_target && pos_q == tgt_q) begin
        tgt_d = tick_i.target_step;
        ovf_d = tick_i.target_step > cfg_i.max_target_step;
      end
      diff = tgt_d - pos_q;
      if (pos_q != tgt_d) begin
        stepped = 1'b1;
        // The sign of the wrapped difference picks the shorter way round.
        if (!diff[PosW-1]) begin
          phase_d = phase_up;
          pos_d   = pos_q + 1'b1;
          went_up = 1'b1;
        end else begin
          phase_d = phase_dn;
          pos_d   = pos_q - 1'b1;
        end
      end
      mode_d = (pos_d != tgt_d) ? MODE_MOVING : MODE_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= '0;
      pos_q   <= '0;
      tgt_q   <= '0;
      left_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (tick_valid_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      left_q  <= left_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    result_o.phase_pattern = coil_pattern(phase_d);
    result_o.step_taken    = stepped;
    result_o.step_up       = went_up;
    result_o.position      = pos_d;
    result_o.moving        = pos_d != tgt_d;
    result_o.over_limit    = ovf_d;
    result_o.homing        = mode_d == MODE_HOMING;
    result_o.home_result   = res;
  end

endmodule
